>>> rtl/binomial_probability_defines.svh
// Assertion macros for the binomial probability block.
`ifndef BINOMIAL_PROBABILITY_DEFINES_SVH
`define BINOMIAL_PROBABILITY_DEFINES_SVH

`ifndef ASSERT_OFF
`define BP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binomial_probability: check failed");
`define BP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binomial_probability: check failed");
`else
`define BP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/bp_pkg.sv
`timescale 1ns / 1ps

package bp_pkg;

    typedef logic [32:0] q32_t;

    typedef struct packed {
        logic [2:0]  shift;
        logic [31:0] inv;
    } div_entry_t;

    localparam q32_t ONE_Q32 = 33'h1_0000_0000;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // exact division by d = 2^shift * m: shift out, then multiply by m^-1 mod 2^32
    function automatic div_entry_t div_entry(input logic [4:0] d);
        div_entry_t e;
        unique case (d)
            5'd1:    e = '{shift: 3'd0, inv: 32'h0000_0001};
            5'd2:    e = '{shift: 3'd1, inv: 32'h0000_0001};
            5'd3:    e = '{shift: 3'd0, inv: 32'hAAAA_AAAB};
            5'd4:    e = '{shift: 3'd2, inv: 32'h0000_0001};
            5'd5:    e = '{shift: 3'd0, inv: 32'hCCCC_CCCD};
            5'd6:    e = '{shift: 3'd1, inv: 32'hAAAA_AAAB};
            5'd7:    e = '{shift: 3'd0, inv: 32'hB6DB_6DB7};
            5'd8:    e = '{shift: 3'd3, inv: 32'h0000_0001};
            5'd9:    e = '{shift: 3'd0, inv: 32'h38E3_8E39};
            5'd10:   e = '{shift: 3'd1, inv: 32'hCCCC_CCCD};
            5'd11:   e = '{shift: 3'd0, inv: 32'hBA2E_8BA3};
            5'd12:   e = '{shift: 3'd2, inv: 32'hAAAA_AAAB};
            5'd13:   e = '{shift: 3'd0, inv: 32'hC4EC_4EC5};
            5'd14:   e = '{shift: 3'd1, inv: 32'hB6DB_6DB7};
            5'd15:   e = '{shift: 3'd0, inv: 32'hEEEE_EEEF};
            5'd16:   e = '{shift: 3'd4, inv: 32'h0000_0001};
            default: e = '{shift: 3'd0, inv: 32'h0000_0001};
        endcase
        return e;
    endfunction

endpackage

>>> rtl/binomial_probability.sv
// Binomial probability: C(n,k) * p^k * (1-p)^(n-k) on one shared 32x32 multiplier.
// With the coefficient override the C(n,k) loop is skipped; when k > n no product is
// formed and the result is zero with range status.
// One request at a time; in_stall stays high until the result is loaded into the output registers.
// Reset (rst_n low, asynchronous) clears the sequencer, the output valid and both registers.
`timescale 1ns / 1ps
`include "binomial_probability_defines.svh"

module binomial_probability
    import bp_pkg::*;
#(
    parameter int MAX_TRIALS     = 32,
    parameter int PROB_FRAC_BITS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  trials,
    input  logic [5:0]  successes,
    input  logic [16:0] success_prob,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [32:0] probability,
    output logic [31:0] coefficient,
    output logic [1:0]  status,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [0:0] REG_OVR_EN  = 1'd0;
    localparam logic [0:0] REG_OVR_VAL = 1'd1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CF_CHK = 4'd1;
    localparam logic [3:0] S_CF_DIV = 4'd2;
    localparam logic [3:0] S_CF_WB  = 4'd3;
    localparam logic [3:0] S_PK_CHK = 4'd4;
    localparam logic [3:0] S_PK_WB  = 4'd5;
    localparam logic [3:0] S_QK_CHK = 4'd6;
    localparam logic [3:0] S_QK_WB  = 4'd7;
    localparam logic [3:0] S_T_WB   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    localparam logic [5:0] N_MAX = 6'(MAX_TRIALS);
    localparam q32_t       ONE_P = ONE_Q32 >> (32 - PROB_FRAC_BITS);

    logic [3:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        ovr_en_reg;
    logic [31:0] ovr_val_reg;

    logic [5:0]  n_reg, n_next;
    logic [5:0]  k_reg, k_next;
    logic [5:0]  km_reg, km_next;
    logic [5:0]  i_reg, i_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] coeff_reg, coeff_next;
    q32_t        p32_reg, p32_next;
    q32_t        acc_reg, acc_next;
    q32_t        pk_reg, pk_next;
    logic [32:0] res_prob_reg, res_prob_next;
    logic [1:0]  res_status_reg, res_status_next;

    logic [32:0] probability_reg;
    logic [31:0] coefficient_reg;
    logic [1:0]  status_reg;
    logic        out_load;

    logic        mul_en;
    q32_t        mul_a;
    q32_t        mul_b;
    logic [63:0] mul_prod;
    q32_t        mul_q32;

    logic [5:0]  n_sat;
    logic [5:0]  k_sat;
    logic [5:0]  nk_sat;
    q32_t        p_ext;
    q32_t        p_sat;
    q32_t        q32_val;
    div_entry_t  div_e;
    logic [35:0] cf_x;
    logic [31:0] cf_y;

    bp_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod),
        .q32  (mul_q32)
    );

    assign n_sat   = (trials > N_MAX) ? N_MAX : trials;
    assign k_sat   = (successes > N_MAX) ? N_MAX : successes;
    assign nk_sat  = n_sat - k_sat;
    assign p_ext   = 33'(success_prob);
    assign p_sat   = (p_ext > ONE_P) ? ONE_P : p_ext;
    assign q32_val = ONE_Q32 - p32_reg;
    assign div_e   = div_entry(5'(i_reg + 6'd1));
    assign cf_x    = mul_prod[35:0];
    assign cf_y    = 32'(cf_x >> div_e.shift);

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        km_next         = km_reg;
        i_next          = i_reg;
        c_next          = c_reg;
        coeff_next      = coeff_reg;
        p32_next        = p32_reg;
        acc_next        = acc_reg;
        pk_next         = pk_reg;
        res_prob_next   = res_prob_reg;
        res_status_next = res_status_reg;
        out_load        = 1'b0;
        mul_en          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next   = n_sat;
                    k_next   = k_sat;
                    km_next  = (k_sat > nk_sat) ? nk_sat : k_sat;
                    p32_next = 33'(p_sat << (32 - PROB_FRAC_BITS));
                    i_next   = '0;
                    c_next   = 32'd1;
                    acc_next = ONE_Q32;
                    if (k_sat > n_sat)
                    begin
                        res_prob_next   = '0;
                        coeff_next      = ovr_en_reg ? ovr_val_reg : '0;
                        res_status_next = ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else if (ovr_en_reg)
                    begin
                        coeff_next = ovr_val_reg;
                        state_next = S_PK_CHK;
                    end
                    else
                    begin
                        state_next = S_CF_CHK;
                    end
                end
            end
            S_CF_CHK:
            begin
                if (i_reg == km_reg)
                begin
                    coeff_next = c_reg;
                    i_next     = '0;
                    state_next = S_PK_CHK;
                end
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = {1'b0, c_reg};
                    mul_b      = 33'(n_reg - i_reg);
                    state_next = S_CF_DIV;
                end
            end
            S_CF_DIV:
            begin
                mul_en     = 1'b1;
                mul_a      = {1'b0, cf_y};
                mul_b      = {1'b0, div_e.inv};
                state_next = S_CF_WB;
            end
            S_CF_WB:
            begin
                c_next     = mul_prod[31:0];
                i_next     = i_reg + 6'd1;
                state_next = S_CF_CHK;
            end
            S_PK_CHK:
            begin
                if (i_reg == k_reg)
                begin
                    pk_next    = acc_reg;
                    acc_next   = ONE_Q32;
                    i_next     = '0;
                    state_next = S_QK_CHK;
                end
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = acc_reg;
                    mul_b      = p32_reg;
                    state_next = S_PK_WB;
                end
            end
            S_PK_WB:
            begin
                acc_next   = mul_q32;
                i_next     = i_reg + 6'd1;
                state_next = S_PK_CHK;
            end
            S_QK_CHK:
            begin
                mul_en = 1'b1;
                if (i_reg == (n_reg - k_reg))
                begin
                    mul_a      = pk_reg;
                    mul_b      = acc_reg;
                    state_next = S_T_WB;
                end
                else
                begin
                    mul_a      = acc_reg;
                    mul_b      = q32_val;
                    state_next = S_QK_WB;
                end
            end
            S_QK_WB:
            begin
                acc_next   = mul_q32;
                i_next     = i_reg + 6'd1;
                state_next = S_QK_CHK;
            end
            S_T_WB:
            begin
                acc_next   = mul_q32;
                mul_en     = 1'b1;
                mul_a      = {1'b0, coeff_reg};
                mul_b      = {1'b0, mul_q32[31:0]};
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (acc_reg[32])
                begin
                    res_prob_next   = (coeff_reg == '0) ? '0 : ONE_Q32;
                    res_status_next = (coeff_reg > 32'd1) ? ST_SAT : ST_OK;
                end
                else if (mul_prod > 64'(ONE_Q32))
                begin
                    res_prob_next   = ONE_Q32;
                    res_status_next = ST_SAT;
                end
                else
                begin
                    res_prob_next   = mul_prod[32:0];
                    res_status_next = ST_OK;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ovr_en_reg    <= 1'b0;
            ovr_val_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == REG_OVR_EN))
            begin
                ovr_en_reg <= cfg_data[0];
            end
            if (cfg_write && (cfg_index == REG_OVR_VAL))
            begin
                ovr_val_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        k_reg          <= k_next;
        km_reg         <= km_next;
        i_reg          <= i_next;
        c_reg          <= c_next;
        coeff_reg      <= coeff_next;
        p32_reg        <= p32_next;
        acc_reg        <= acc_next;
        pk_reg         <= pk_next;
        res_prob_reg   <= res_prob_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            probability_reg <= res_prob_reg;
            coefficient_reg <= coeff_reg;
            status_reg      <= res_status_reg;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign probability = probability_reg;
    assign coefficient = coefficient_reg;
    assign status      = status_reg;

    `BP_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)
    `BP_ASSERT_IMP(a_range_zero, clk, rst_n, out_valid_reg && (status_reg == ST_RANGE), probability_reg == '0)
    `BP_ASSERT_IMP(a_sat_one, clk, rst_n, out_valid_reg && (status_reg == ST_SAT), probability_reg == ONE_Q32)
    `BP_ASSERT_IMP(a_prob_bound, clk, rst_n, out_valid_reg, probability_reg <= ONE_Q32)
    `BP_ASSERT_IMP(a_pow_count, clk, rst_n, state_reg == S_PK_WB, i_reg < k_reg)

endmodule

>>> rtl/bp_mul.sv
`timescale 1ns / 1ps

module bp_mul
    import bp_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  q32_t        a,
    input  q32_t        b,
    output logic [63:0] prod,
    output q32_t        q32
);

    q32_t        a_reg;
    q32_t        b_reg;
    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a;
            b_reg    <= b;
            prod_reg <= 64'(a[31:0]) * 64'(b[31:0]);
        end
    end

    assign prod = prod_reg;

    // a factor with bit 32 set (1.0) passes the other one through; a is checked first
    always_comb
    begin
        priority if (a_reg[32])
        begin
            q32 = b_reg;
        end
        else if (b_reg[32])
        begin
            q32 = a_reg;
        end
        else
        begin
            q32 = {1'b0, prod_reg[63:32]};
        end
    end

endmodule
